// ===== src/text_console_with_dirty_map_defines.svh =====
// assertion macros for the text console block
// included by the files that carry concurrent assertions
`ifndef TEXT_CONSOLE_WITH_DIRTY_MAP_DEFINES_SVH
`define TEXT_CONSOLE_WITH_DIRTY_MAP_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define TCD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text console assertion failed");
// antecedent implies consequent in the next cycle
`define TCD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text console assertion failed");
`else
`define TCD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TCD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/tcd_pkg.sv =====
// shared sizes, codes, types and helper functions of the text console
// used by every module of the block; depends on nothing
package tcd_pkg;

  // screen geometry limits
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 32;
  localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;

  // derived widths
  localparam int CA_W   = $clog2(CELLS);
  localparam int N_W    = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int PROD_W = ROW_W + COL_W + 1;

  // dirty map word organization
  localparam int DW     = 32;
  localparam int BIT_W  = $clog2(DW);
  localparam int DWORDS = (CELLS + DW - 1) / DW;
  localparam int DWI_W  = (DWORDS > 1) ? $clog2(DWORDS) : 1;
  localparam int WC_W   = DWI_W + 1;
  localparam int WB_W   = WC_W + BIT_W;

  // divider step counter
  localparam int DIV_CNT_W = $clog2(CA_W + 1);

  // fixed port widths
  localparam int OP_W       = 3;
  localparam int CHAR_W     = 8;
  localparam int TCOL_W     = 7;
  localparam int TROW_W     = 5;
  localparam int CFG_COL_W  = 8;
  localparam int CFG_ROW_W  = 6;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // register reset values
  localparam logic [CFG_COL_W-1:0] COLS_RESET = CFG_COL_W'(80);
  localparam logic [CFG_ROW_W-1:0] ROWS_RESET = CFG_ROW_W'(25);

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] CH_SPACE     = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CH_LAST_CTRL = CHAR_W'(31);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_SETPOS  = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_REFRESH = 3'd3,
    OP_DRAIN   = 3'd4
  } op_t;

  // access request to the character store and dirty map
  typedef struct packed {
    logic              rd_en;
    logic [CA_W-1:0]   rd_a_addr;
    logic [CA_W-1:0]   rd_b_addr;
    logic              wr_en;
    logic [CA_W-1:0]   wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              dirty_rd_en;
    logic [DWI_W-1:0]  dirty_rd_addr;
    logic              dirty_wr_en;
    logic [DWI_W-1:0]  dirty_wr_addr;
    logic [DW-1:0]     dirty_wr_mask;
    logic [DW-1:0]     dirty_wr_data;
  } store_req_t;

  // dirty word that holds a cell
  function automatic logic [DWI_W-1:0] word_of(input logic [CA_W-1:0] a);
    return DWI_W'(a >> BIT_W);
  endfunction

  // one-hot mask of a cell inside its dirty word
  function automatic logic [DW-1:0] bit_mask(input logic [CA_W-1:0] a);
    logic [BIT_W-1:0] b;
    b = BIT_W'(a);
    return DW'(1) << b;
  endfunction

  // bits of a word that lie below the end of the screen
  function automatic logic [DW-1:0] valid_mask(input logic [N_W-1:0] remaining);
    logic [DW-1:0] m;
    for (int i = 0; i < DW; i++) begin
      m[i] = (int'(remaining) > i);
    end
    return m;
  endfunction

  // index of the lowest set bit
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [DW-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== src/tcd_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// splits a linear cell address into row and column; uses tcd_pkg
module tcd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tcd_pkg::CA_W-1:0]   dividend,
  input  logic [tcd_pkg::COL_W-1:0]  divisor,
  output logic                       done,
  output logic [tcd_pkg::CA_W-1:0]   quotient,
  output logic [tcd_pkg::COL_W-1:0]  remainder
);

  logic                          busy;
  logic [tcd_pkg::DIV_CNT_W-1:0] cnt;
  logic [tcd_pkg::CA_W-1:0]      quo;
  logic [tcd_pkg::COL_W-1:0]     rem;
  logic [tcd_pkg::COL_W-1:0]     div_q;
  logic [tcd_pkg::COL_W:0]       trial;
  logic [tcd_pkg::COL_W:0]       diff;
  logic                          fits;

  // one trial subtraction
  always_comb begin
    trial = {rem, quo[tcd_pkg::CA_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tcd_pkg::DIV_CNT_W'(tcd_pkg::CA_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == tcd_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend;
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      quo <= {quo[tcd_pkg::CA_W-2:0], fits};
      rem <= fits ? diff[tcd_pkg::COL_W-1:0] : trial[tcd_pkg::COL_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== src/tcd_store.sv =====
// character store and dirty map memories with registered reads
// driven by a tcd_pkg::store_req_t request from the sequencer
module tcd_store (
  input  logic                        clk,
  input  tcd_pkg::store_req_t         req,
  output logic [tcd_pkg::CHAR_W-1:0]  rd_a_data,
  output logic [tcd_pkg::CHAR_W-1:0]  rd_b_data,
  output logic [tcd_pkg::DW-1:0]      dirty_rd_data
);

  logic [tcd_pkg::CHAR_W-1:0] char_mem  [tcd_pkg::CELLS];
  logic [tcd_pkg::DW-1:0]     dirty_mem [tcd_pkg::DWORDS];

  // character store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      char_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_a_data <= char_mem[req.rd_a_addr];
      rd_b_data <= char_mem[req.rd_b_addr];
    end
  end

  // dirty map: bit-masked write, one read port
  always_ff @(posedge clk) begin
    if (req.dirty_wr_en) begin
      for (int i = 0; i < tcd_pkg::DW; i++) begin
        if (req.dirty_wr_mask[i]) begin
          dirty_mem[req.dirty_wr_addr][i] <= req.dirty_wr_data[i];
        end
      end
    end
    if (req.dirty_rd_en) begin
      dirty_rd_data <= dirty_mem[req.dirty_rd_addr];
    end
  end

endmodule

// ===== src/text_console_with_dirty_map.sv =====
// text console top level: sequencer, cursor, configuration and result register
// uses tcd_pkg, tcd_store, tcd_div and the assertion macro header
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  cmd      | cmd_valid / cmd_stall | operation, char_code, target_column, target_row
//  draw     | draw_valid/draw_stall | found, draw_column, draw_row, draw_char
//  cfg      | cfg_write             | cfg_index, cfg_data
//
// one item at a time through a single sequencer over one store port pair
// write char wraps, scrolls if below the last row, then writes the cell if it changes
// clear sweeps n cells (n = rows * columns in use), refresh marks them a word at a time
// set position and newline finish in idle; drain scans dirty words for a hit
// after reset a clearing pass over every cell runs with cmd_stall high
// a waiting result sits in the output register; only a drain waits behind it
`include "text_console_with_dirty_map_defines.svh"
module text_console_with_dirty_map (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [tcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  logic [tcd_pkg::OP_W-1:0]        operation,
  input  logic [tcd_pkg::CHAR_W-1:0]      char_code,
  input  logic [tcd_pkg::TCOL_W-1:0]      target_column,
  input  logic [tcd_pkg::TROW_W-1:0]      target_row,
  output logic                            draw_valid,
  input  logic                            draw_stall,
  output logic                            found,
  output logic [tcd_pkg::TCOL_W-1:0]      draw_column,
  output logic [tcd_pkg::TROW_W-1:0]      draw_row,
  output logic [tcd_pkg::CHAR_W-1:0]      draw_char
);

  typedef enum logic [14:0] {
    ST_INIT    = 15'h0001,
    ST_IDLE    = 15'h0002,
    ST_WRAP    = 15'h0004,
    ST_CHECK   = 15'h0008,
    ST_SCROLL  = 15'h0010,
    ST_ADDR    = 15'h0020,
    ST_READ    = 15'h0040,
    ST_CMP     = 15'h0080,
    ST_CLEAR   = 15'h0100,
    ST_REFRESH = 15'h0200,
    ST_D_RD    = 15'h0400,
    ST_D_EV    = 15'h0800,
    ST_D_CHAR  = 15'h1000,
    ST_D_DIV   = 15'h2000,
    ST_D_OUT   = 15'h4000
  } state_t;

  state_t state, state_next;

  // control registers
  logic [tcd_pkg::CFG_COL_W-1:0] columns_in_use;
  logic [tcd_pkg::CFG_ROW_W-1:0] rows_in_use;
  logic [tcd_pkg::COL_W-1:0]     cursor_column, cursor_column_next;
  logic [tcd_pkg::ROW_W-1:0]     cursor_row, cursor_row_next;
  logic [tcd_pkg::N_W-1:0]       sweep, sweep_next;
  logic [tcd_pkg::WC_W-1:0]      word, word_next;
  logic                          sv, sv_next;
  logic [tcd_pkg::N_W-1:0]       n_cells;

  // payload registers
  logic [tcd_pkg::CHAR_W-1:0]    ch_q, ch_next;
  logic [tcd_pkg::CA_W-1:0]      wa, wa_next;
  logic                          src_space, src_space_next;
  logic [tcd_pkg::CA_W-1:0]      cell_addr, cell_addr_next;
  logic [tcd_pkg::CA_W-1:0]      hit_addr, hit_addr_next;
  logic                          res_found, res_found_next;
  logic [tcd_pkg::TCOL_W-1:0]    res_col, res_col_next;
  logic [tcd_pkg::TROW_W-1:0]    res_row, res_row_next;
  logic [tcd_pkg::CHAR_W-1:0]    res_char, res_char_next;

  // helpers
  logic [tcd_pkg::COL_W-1:0]     c_eff;
  logic [tcd_pkg::ROW_W-1:0]     r_eff;
  logic [tcd_pkg::PROD_W-1:0]    addr_calc;
  logic [tcd_pkg::PROD_W-1:0]    n_calc;
  logic [tcd_pkg::N_W-1:0]       last_cell;
  logic [tcd_pkg::N_W-1:0]       fill_limit;
  logic [tcd_pkg::WB_W-1:0]      base;
  logic [tcd_pkg::WB_W-1:0]      n_ext;
  logic [tcd_pkg::N_W-1:0]       rem_cells;
  logic [tcd_pkg::DW-1:0]        live_word;
  logic [tcd_pkg::BIT_W-1:0]     hit_bit;
  logic [tcd_pkg::CHAR_W-1:0]    scroll_new;
  logic                          cmd_take;
  logic                          out_load;

  // store and divider
  tcd_pkg::store_req_t           req;
  logic [tcd_pkg::CHAR_W-1:0]    rd_a_data;
  logic [tcd_pkg::CHAR_W-1:0]    rd_b_data;
  logic [tcd_pkg::DW-1:0]        dirty_rd_data;
  logic                          div_start;
  logic                          div_done;
  logic [tcd_pkg::CA_W-1:0]      div_quo;
  logic [tcd_pkg::COL_W-1:0]     div_rem;

  tcd_store u_store (
    .clk           (clk),
    .req           (req),
    .rd_a_data     (rd_a_data),
    .rd_b_data     (rd_b_data),
    .dirty_rd_data (dirty_rd_data)
  );

  tcd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (hit_addr),
    .divisor   (c_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // effective screen size
  always_comb begin
    if (columns_in_use == '0) begin
      c_eff = tcd_pkg::COL_W'(1);
    end else if (int'(columns_in_use) > tcd_pkg::MAX_COLUMNS) begin
      c_eff = tcd_pkg::COL_W'(tcd_pkg::MAX_COLUMNS);
    end else begin
      c_eff = tcd_pkg::COL_W'(columns_in_use);
    end
    if (rows_in_use == '0) begin
      r_eff = tcd_pkg::ROW_W'(1);
    end else if (int'(rows_in_use) > tcd_pkg::MAX_ROWS) begin
      r_eff = tcd_pkg::ROW_W'(tcd_pkg::MAX_ROWS);
    end else begin
      r_eff = tcd_pkg::ROW_W'(rows_in_use);
    end
  end

  // address arithmetic
  always_comb begin
    addr_calc  = tcd_pkg::PROD_W'(cursor_row) * tcd_pkg::PROD_W'(c_eff)
                 + tcd_pkg::PROD_W'(cursor_column);
    n_calc     = tcd_pkg::PROD_W'(r_eff) * tcd_pkg::PROD_W'(c_eff);
    last_cell  = n_cells - tcd_pkg::N_W'(c_eff);
    fill_limit = (state == ST_INIT) ? tcd_pkg::N_W'(tcd_pkg::CELLS) : n_cells;
    base       = {word, tcd_pkg::BIT_W'(0)};
    n_ext      = tcd_pkg::WB_W'(n_cells);
    rem_cells  = tcd_pkg::N_W'(n_ext - base);
    live_word  = dirty_rd_data & tcd_pkg::valid_mask(rem_cells);
    hit_bit    = tcd_pkg::lowest_bit(live_word);
    scroll_new = src_space ? tcd_pkg::CH_SPACE : rd_a_data;
  end

  assign cmd_stall = (state != ST_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign out_load  = (state == ST_D_OUT) && (!draw_valid || !draw_stall);

  // sequencer
  always_comb begin
    state_next         = state;
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    sweep_next         = sweep;
    word_next          = word;
    sv_next            = 1'b0;
    ch_next            = ch_q;
    wa_next            = wa;
    src_space_next     = src_space;
    cell_addr_next     = cell_addr;
    hit_addr_next      = hit_addr;
    res_found_next     = res_found;
    res_col_next       = res_col;
    res_row_next       = res_row;
    res_char_next      = res_char;
    req                = '0;
    div_start          = 1'b0;

    case (state)
      // fill sweep: spaces and dirty, one cell a cycle
      ST_INIT, ST_CLEAR: begin
        if (sweep < fill_limit) begin
          req.wr_en         = 1'b1;
          req.wr_addr       = tcd_pkg::CA_W'(sweep);
          req.wr_data       = tcd_pkg::CH_SPACE;
          req.dirty_wr_en   = 1'b1;
          req.dirty_wr_addr = tcd_pkg::word_of(tcd_pkg::CA_W'(sweep));
          req.dirty_wr_mask = tcd_pkg::bit_mask(tcd_pkg::CA_W'(sweep));
          req.dirty_wr_data = '1;
          sweep_next        = sweep + 1'b1;
        end else begin
          sweep_next         = '0;
          cursor_column_next = '0;
          cursor_row_next    = '0;
          state_next         = ST_IDLE;
        end
      end

      // take an item and dispatch
      ST_IDLE: begin
        if (cmd_take) begin
          ch_next = char_code;
          case (operation)
            tcd_pkg::OP_WRITE: begin
              if (char_code == tcd_pkg::CH_NEWLINE) begin
                cursor_column_next = '0;
                if (int'(cursor_row) < tcd_pkg::MAX_ROWS) begin
                  cursor_row_next = cursor_row + 1'b1;
                end
              end else if (char_code > tcd_pkg::CH_LAST_CTRL) begin
                state_next = ST_WRAP;
              end
            end
            tcd_pkg::OP_SETPOS: begin
              if (int'(target_column) > int'(c_eff) - 1) begin
                cursor_column_next = c_eff - 1'b1;
              end else begin
                cursor_column_next = tcd_pkg::COL_W'(target_column);
              end
              if (int'(target_row) > int'(r_eff) - 1) begin
                cursor_row_next = r_eff - 1'b1;
              end else begin
                cursor_row_next = tcd_pkg::ROW_W'(target_row);
              end
            end
            tcd_pkg::OP_CLEAR: begin
              sweep_next = '0;
              state_next = ST_CLEAR;
            end
            tcd_pkg::OP_REFRESH: begin
              word_next  = '0;
              state_next = ST_REFRESH;
            end
            tcd_pkg::OP_DRAIN: begin
              word_next  = '0;
              state_next = ST_D_RD;
            end
            default: begin
            end
          endcase
        end
      end

      // wrap past the last column
      ST_WRAP: begin
        if (cursor_column >= c_eff) begin
          cursor_column_next = '0;
          if (int'(cursor_row) < tcd_pkg::MAX_ROWS) begin
            cursor_row_next = cursor_row + 1'b1;
          end
        end
        state_next = ST_CHECK;
      end

      // scroll when below the last row
      ST_CHECK: begin
        if (cursor_row >= r_eff) begin
          sweep_next         = '0;
          cursor_row_next    = r_eff - 1'b1;
          cursor_column_next = '0;
          state_next         = ST_SCROLL;
        end else begin
          state_next = ST_ADDR;
        end
      end

      // scroll pipeline: read one row below, write back in the next cycle
      ST_SCROLL: begin
        if (sweep < n_cells) begin
          req.rd_en      = 1'b1;
          req.rd_a_addr  = tcd_pkg::CA_W'(sweep + tcd_pkg::N_W'(c_eff));
          req.rd_b_addr  = tcd_pkg::CA_W'(sweep);
          sv_next        = 1'b1;
          wa_next        = tcd_pkg::CA_W'(sweep);
          src_space_next = (sweep >= last_cell);
          sweep_next     = sweep + 1'b1;
        end else if (!sv) begin
          state_next = ST_ADDR;
        end
        if (sv && (rd_b_data != scroll_new)) begin
          req.wr_en         = 1'b1;
          req.wr_addr       = wa;
          req.wr_data       = scroll_new;
          req.dirty_wr_en   = 1'b1;
          req.dirty_wr_addr = tcd_pkg::word_of(wa);
          req.dirty_wr_mask = tcd_pkg::bit_mask(wa);
          req.dirty_wr_data = '1;
        end
      end

      // cursor cell address
      ST_ADDR: begin
        cell_addr_next = tcd_pkg::CA_W'(addr_calc);
        state_next     = ST_READ;
      end

      ST_READ: begin
        req.rd_en     = 1'b1;
        req.rd_b_addr = cell_addr;
        state_next    = ST_CMP;
      end

      // store the character only if it changes the cell
      ST_CMP: begin
        if (rd_b_data != ch_q) begin
          req.wr_en         = 1'b1;
          req.wr_addr       = cell_addr;
          req.wr_data       = ch_q;
          req.dirty_wr_en   = 1'b1;
          req.dirty_wr_addr = tcd_pkg::word_of(cell_addr);
          req.dirty_wr_mask = tcd_pkg::bit_mask(cell_addr);
          req.dirty_wr_data = '1;
        end
        cursor_column_next = cursor_column + 1'b1;
        state_next         = ST_IDLE;
      end

      // mark dirty a word at a time
      ST_REFRESH: begin
        if (base < n_ext) begin
          req.dirty_wr_en   = 1'b1;
          req.dirty_wr_addr = tcd_pkg::DWI_W'(word);
          req.dirty_wr_mask = tcd_pkg::valid_mask(rem_cells);
          req.dirty_wr_data = '1;
          word_next         = word + 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end

      // drain scan: fetch next dirty word
      ST_D_RD: begin
        if (base < n_ext) begin
          req.dirty_rd_en   = 1'b1;
          req.dirty_rd_addr = tcd_pkg::DWI_W'(word);
          state_next        = ST_D_EV;
        end else begin
          res_found_next = 1'b0;
          res_col_next   = '0;
          res_row_next   = '0;
          res_char_next  = '0;
          state_next     = ST_D_OUT;
        end
      end

      ST_D_EV: begin
        if (live_word != '0) begin
          hit_addr_next = tcd_pkg::CA_W'(base + tcd_pkg::WB_W'(hit_bit));
          state_next    = ST_D_CHAR;
        end else begin
          word_next  = word + 1'b1;
          state_next = ST_D_RD;
        end
      end

      // fetch the byte, clear the bit, split the address
      ST_D_CHAR: begin
        req.rd_en         = 1'b1;
        req.rd_b_addr     = hit_addr;
        req.dirty_wr_en   = 1'b1;
        req.dirty_wr_addr = tcd_pkg::word_of(hit_addr);
        req.dirty_wr_mask = tcd_pkg::bit_mask(hit_addr);
        req.dirty_wr_data = '0;
        div_start         = 1'b1;
        state_next        = ST_D_DIV;
      end

      ST_D_DIV: begin
        if (div_done) begin
          res_found_next = 1'b1;
          res_col_next   = tcd_pkg::TCOL_W'(div_rem);
          res_row_next   = tcd_pkg::TROW_W'(div_quo);
          res_char_next  = rd_b_data;
          state_next     = ST_D_OUT;
        end
      end

      ST_D_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT;
      cursor_column  <= '0;
      cursor_row     <= '0;
      sweep          <= '0;
      word           <= '0;
      sv             <= 1'b0;
      columns_in_use <= tcd_pkg::COLS_RESET;
      rows_in_use    <= tcd_pkg::ROWS_RESET;
      n_cells        <= '0;
    end else begin
      state         <= state_next;
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      sweep         <= sweep_next;
      word          <= word_next;
      sv            <= sv_next;
      n_cells       <= tcd_pkg::N_W'(n_calc);
      if (cfg_write) begin
        case (cfg_index)
          tcd_pkg::REG_COLUMNS: columns_in_use <= cfg_data;
          tcd_pkg::REG_ROWS:    rows_in_use    <= tcd_pkg::CFG_ROW_W'(cfg_data);
          default: begin
          end
        endcase
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    ch_q      <= ch_next;
    wa        <= wa_next;
    src_space <= src_space_next;
    cell_addr <= cell_addr_next;
    hit_addr  <= hit_addr_next;
    res_found <= res_found_next;
    res_col   <= res_col_next;
    res_row   <= res_row_next;
    res_char  <= res_char_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_valid <= 1'b0;
    end else if (out_load) begin
      draw_valid <= 1'b1;
    end else if (!draw_stall) begin
      draw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found       <= res_found;
      draw_column <= res_col;
      draw_row    <= res_row;
      draw_char   <= res_char;
    end
  end

  // checks
  `TCD_ASSERT_IMPL(a_cell_on_screen, clk, rst, state == ST_CMP,
                   tcd_pkg::N_W'(cell_addr) < n_cells)
  `TCD_ASSERT_IMPL(a_hit_on_screen, clk, rst, state == ST_D_CHAR,
                   tcd_pkg::N_W'(hit_addr) < n_cells)
  `TCD_ASSERT_IMPL(a_scroll_write_on_screen, clk, rst, state == ST_SCROLL && sv,
                   tcd_pkg::N_W'(wa) < n_cells)
  `TCD_ASSERT_IMPL(a_result_from_drain, clk, rst, $rose(draw_valid),
                   $past(state == ST_D_OUT))
  `TCD_ASSERT_NEXT(a_div_start_waits, clk, rst, div_start,
                   state == ST_D_DIV && !div_done)

endmodule
